// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file lfs_checker.sv
// each macro expects clk and rst_n to be visible where it is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped during reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, skipped during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lfs_pkg.sv =====
// shared types, codes and constants of the lcd frame scan block
// no dependencies
package lfs_pkg;

    // display geometry
    localparam int DISPLAY_WIDTH  = 48;
    localparam int DISPLAY_HEIGHT = 32;
    localparam int PIXEL_COUNT    = DISPLAY_WIDTH * DISPLAY_HEIGHT;
    localparam int PIX_W          = $clog2(PIXEL_COUNT);

    // frame memory geometry
    localparam int BANK_COUNT = 3;
    localparam int BANK_BYTES = 128;
    localparam int FRAME_DEPTH = BANK_COUNT * BANK_BYTES;
    localparam int FRAME_AW    = $clog2(FRAME_DEPTH);
    localparam int ROW_BYTES   = 6;

    // persistence levels
    localparam int GHOST_FRAMES = 8;
    localparam int LVL_W        = 4;
    localparam logic [LVL_W-1:0] GHOST_MAX = LVL_W'(GHOST_FRAMES);

    // scan start offset of the display start register
    localparam logic [7:0] START_OFFSET = 8'h83;

    // command modes
    localparam logic [1:0] MODE_WRITE   = 2'd0;
    localparam logic [1:0] MODE_REFRESH = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    // register indexes
    localparam logic [1:0] CFG_GHOST = 2'd0;
    localparam logic [1:0] CFG_START = 2'd1;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CLEAR = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_READ  = 5'b10000
    } state_t;

    // control of the scan address walker
    typedef struct packed {
        logic load;
        logic advance;
    } scan_ctrl_t;

endpackage

// ===== hw/rtl/lfs_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module lfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 384
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/lfs_scan_addr.sv =====
// frame memory byte address walker for the refresh scan
// depends on lfs_pkg
module lfs_scan_addr
    import lfs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  scan_ctrl_t          ctrl,
    input  logic [7:0]          scan_start,
    output logic [FRAME_AW-1:0] addr
);

    logic [1:0] bank_reg, bank_next;
    logic [6:0] ptr_reg, ptr_next;
    logic [7:0] start_adj;
    logic [7:0] q;
    logic [1:0] b;

    always_comb
    begin
        // start point from the display start register
        start_adj = (scan_start >= START_OFFSET) ? scan_start - START_OFFSET : scan_start;

        // one byte forward: skip the row gap, cross banks, wrap bank 2
        q = {1'b0, ptr_reg} + 8'd1;
        b = bank_reg;
        if (q[3:0] >= 4'd12)
        begin
            q = q + 8'd4;
        end
        if (q >= 8'(BANK_BYTES))
        begin
            b = b + 2'd1;
            q = q - 8'(BANK_BYTES);
        end
        if (b == 2'd2 && q >= 8'(ROW_BYTES))
        begin
            b = 2'd0;
            q = q - 8'(ROW_BYTES);
        end

        priority if (ctrl.load)
        begin
            bank_next = start_adj[7:6];
            ptr_next  = {start_adj[5:0], 1'b0};
        end
        else if (ctrl.advance)
        begin
            bank_next = b;
            ptr_next  = q[6:0];
        end
        else
        begin
            bank_next = bank_reg;
            ptr_next  = ptr_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg <= 2'd0;
            ptr_reg  <= 7'd0;
        end
        else
        begin
            bank_reg <= bank_next;
            ptr_reg  <= ptr_next;
        end
    end

    assign addr = FRAME_AW'({bank_reg, ptr_reg});

endmodule

// ===== hw/rtl/lfs_level_alu.sv =====
// shared level update unit: one pixel's saturating step per use
// depends on lfs_pkg
module lfs_level_alu
    import lfs_pkg::*;
(
    input  logic             ghost_enable,
    input  logic [LVL_W:0]   stored,
    input  logic             pix_bit,
    output logic [LVL_W-1:0] new_level,
    output logic             changed
);

    logic [LVL_W-1:0] prev;
    logic [LVL_W-1:0] step;
    logic [LVL_W:0]   sum;

    always_comb
    begin
        // a never-drawn pixel starts from zero
        prev = stored[LVL_W] ? stored[LVL_W-1:0] : '0;
        step = ghost_enable ? LVL_W'(1) : GHOST_MAX;
        sum  = {1'b0, prev} + {1'b0, step};

        if (pix_bit)
        begin
            new_level = (sum > {1'b0, GHOST_MAX}) ? GHOST_MAX : sum[LVL_W-1:0];
        end
        else
        begin
            new_level = (prev < step) ? '0 : prev - step;
        end

        changed = !stored[LVL_W] || (new_level != prev);
    end

endmodule

// ===== hw/rtl/lcd_frame_scan_with_ghosting.sv =====
// top level of the lcd frame scan block: sequencer, frame and level memories
// depends on lfs_pkg, lfs_ram, lfs_scan_addr and lfs_level_alu
//
// A byte write (mode 0) and mode 3 leave busy low, and done pulses on the
// next cycle. A pixel read (mode 2) passes through the read state for the
// registered read of both memories. A refresh (mode 1) scans the 1536 pixels
// in turn and then finishes the last update in the drain state; the shared
// level unit does one read-modify-write of the level memory a cycle. After
// reset the block runs a clearing pass over all 1536 entries of the level
// memory with busy high. Each result is shown for one cycle with done high
// and the receiver cannot stall it. The config channel is always ready.
module lcd_frame_scan_with_ghosting
    import lfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       mode,
    input  logic [1:0]       bank_sel,
    input  logic [6:0]       byte_addr,
    input  logic [7:0]       byte_data,
    input  logic [5:0]       pixel_x,
    input  logic [4:0]       pixel_y,
    output logic             done,
    output logic             screen_changed,
    output logic [LVL_W-1:0] ghost_level,
    output logic             frame_bit,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data
);

    localparam logic [PIX_W-1:0] PIX_LAST = PIX_W'(PIXEL_COUNT - 1);

    state_t state_reg, state_next;

    logic             ghost_enable_reg, ghost_enable_next;
    logic [7:0]       scan_start_reg, scan_start_next;

    logic [PIX_W-1:0] pix_reg, pix_next;
    logic             s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0] s1_pix_reg, s1_pix_next;
    logic [7:0]       byte_hold_reg, byte_hold_next;
    logic             changed_reg, changed_next;

    logic             rd_ok_reg, rd_ok_next;
    logic [2:0]       rd_px_reg, rd_px_next;

    logic             done_reg, done_next;
    logic             screen_changed_reg, screen_changed_next;
    logic [LVL_W-1:0] ghost_level_reg, ghost_level_next;
    logic             frame_bit_reg, frame_bit_next;

    logic                frm_wr_en;
    logic [FRAME_AW-1:0] frm_wr_addr;
    logic [FRAME_AW-1:0] frm_rd_addr;
    logic [7:0]          frm_rd_data;
    logic [FRAME_AW-1:0] scan_addr;

    logic             lvl_wr_en;
    logic [PIX_W-1:0] lvl_wr_addr;
    logic [LVL_W:0]   lvl_wr_data;
    logic [PIX_W-1:0] lvl_rd_addr;
    logic [LVL_W:0]   lvl_rd_data;

    scan_ctrl_t       scan_ctrl;
    logic             accept;
    logic [7:0]       cur_byte;
    logic             cur_bit;
    logic [LVL_W-1:0] new_level;
    logic             pix_changed;
    logic [3:0]       row_in_bank;
    logic [6:0]       read_idx;
    logic [PIX_W-1:0] read_k;

    assign accept    = start && !busy;
    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // frame memory, three banks of bytes
    lfs_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_DEPTH)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (frm_wr_en),
        .wr_addr (frm_wr_addr),
        .wr_data (byte_data),
        .rd_addr (frm_rd_addr),
        .rd_data (frm_rd_data)
    );

    // level memory, drawn flag above the level
    lfs_ram #(
        .WIDTH (LVL_W + 1),
        .DEPTH (PIXEL_COUNT)
    ) u_level_ram (
        .clk     (clk),
        .wr_en   (lvl_wr_en),
        .wr_addr (lvl_wr_addr),
        .wr_data (lvl_wr_data),
        .rd_addr (lvl_rd_addr),
        .rd_data (lvl_rd_data)
    );

    lfs_scan_addr u_scan_addr (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .scan_start (scan_start_reg),
        .addr       (scan_addr)
    );

    lfs_level_alu u_level_alu (
        .ghost_enable (ghost_enable_reg),
        .stored       (lvl_rd_data),
        .pix_bit      (cur_bit),
        .new_level    (new_level),
        .changed      (pix_changed)
    );

    // pixel read addresses
    always_comb
    begin
        row_in_bank = pixel_y[3:0];
        read_idx    = {row_in_bank[3:1], 4'b0000} + (row_in_bank[0] ? 7'(ROW_BYTES) : 7'd0)
                      + 7'(pixel_x[5:3]);
        read_k      = PIX_W'({pixel_y, 5'b00000}) + PIX_W'({pixel_y, 4'b0000})
                      + PIX_W'(pixel_x);
    end

    // byte under the scan: fresh ram data at a byte start, held otherwise
    always_comb
    begin
        cur_byte = (s1_pix_reg[2:0] == 3'd0) ? frm_rd_data : byte_hold_reg;
        cur_bit  = cur_byte[~s1_pix_reg[2:0]];
    end

    // memory port selection
    always_comb
    begin
        frm_wr_en   = accept && (mode == MODE_WRITE) && (bank_sel != 2'd3);
        frm_wr_addr = FRAME_AW'({bank_sel, byte_addr});
        frm_rd_addr = (state_reg == ST_SCAN) ? scan_addr
                                             : FRAME_AW'({pixel_y[4], read_idx});

        lvl_rd_addr = (state_reg == ST_SCAN) ? pix_reg : read_k;

        lvl_wr_en   = (state_reg == ST_CLEAR) || s1_valid_reg;
        lvl_wr_addr = (state_reg == ST_CLEAR) ? pix_reg : s1_pix_reg;
        lvl_wr_data = (state_reg == ST_CLEAR) ? '0 : {1'b1, new_level};

        scan_ctrl.load    = accept && (mode == MODE_REFRESH);
        scan_ctrl.advance = (state_reg == ST_SCAN) && (pix_reg[2:0] == 3'd0);
    end

    // configuration writes
    always_comb
    begin
        ghost_enable_next = ghost_enable_reg;
        scan_start_next   = scan_start_reg;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_GHOST)
            begin
                ghost_enable_next = cfg_data[0];
            end
            else if (cfg_index == CFG_START)
            begin
                scan_start_next = cfg_data;
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next          = state_reg;
        pix_next            = pix_reg;
        s1_valid_next       = 1'b0;
        s1_pix_next         = pix_reg;
        byte_hold_next      = s1_valid_reg ? cur_byte : byte_hold_reg;
        changed_next        = changed_reg || (s1_valid_reg && pix_changed);
        rd_ok_next          = rd_ok_reg;
        rd_px_next          = rd_px_reg;
        done_next           = 1'b0;
        screen_changed_next = 1'b0;
        ghost_level_next    = '0;
        frame_bit_next      = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                pix_next = pix_reg + PIX_W'(1);
                if (pix_reg == PIX_LAST)
                begin
                    pix_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_REFRESH)
                    begin
                        pix_next     = '0;
                        changed_next = 1'b0;
                        state_next   = ST_SCAN;
                    end
                    else if (mode == MODE_READ)
                    begin
                        rd_ok_next = (pixel_x < 6'(DISPLAY_WIDTH));
                        rd_px_next = pixel_x[2:0];
                        state_next = ST_READ;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                s1_valid_next = 1'b1;
                pix_next      = pix_reg + PIX_W'(1);
                if (pix_reg == PIX_LAST)
                begin
                    pix_next   = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                done_next           = 1'b1;
                screen_changed_next = changed_next;
                state_next          = ST_IDLE;
            end
            ST_READ:
            begin
                done_next        = 1'b1;
                ghost_level_next = (rd_ok_reg && lvl_rd_data[LVL_W]) ? lvl_rd_data[LVL_W-1:0]
                                                                    : '0;
                frame_bit_next   = rd_ok_reg && frm_rd_data[~rd_px_reg];
                state_next       = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            pix_reg          <= '0;
            s1_valid_reg     <= 1'b0;
            changed_reg      <= 1'b0;
            done_reg         <= 1'b0;
            ghost_enable_reg <= 1'b0;
            scan_start_reg   <= 8'd0;
        end
        else
        begin
            state_reg        <= state_next;
            pix_reg          <= pix_next;
            s1_valid_reg     <= s1_valid_next;
            changed_reg      <= changed_next;
            done_reg         <= done_next;
            ghost_enable_reg <= ghost_enable_next;
            scan_start_reg   <= scan_start_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_pix_reg         <= s1_pix_next;
        byte_hold_reg      <= byte_hold_next;
        rd_ok_reg          <= rd_ok_next;
        rd_px_reg          <= rd_px_next;
        screen_changed_reg <= screen_changed_next;
        ghost_level_reg    <= ghost_level_next;
        frame_bit_reg      <= frame_bit_next;
    end

    assign done           = done_reg;
    assign screen_changed = screen_changed_reg;
    assign ghost_level    = ghost_level_reg;
    assign frame_bit      = frame_bit_reg;

endmodule

// ===== hw/rtl/lfs_checker.sv =====
// port-level checker of the lcd frame scan block, bound to the top level
// depends on lfs_pkg and assert_macros.svh
`include "assert_macros.svh"

module lfs_checker
    import lfs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic [1:0]       mode,
    input logic             done,
    input logic             screen_changed,
    input logic [LVL_W-1:0] ghost_level,
    input logic             frame_bit
);

    // a result only follows an accepted item or a finished busy period
    `ASSERT_IMPL(a_done_cause, done, $past(start && !busy) || $past(busy), "stray result")

    // a byte write answers next cycle with an all-zero result
    `ASSERT_NEXT(a_write_result, start && !busy && mode == MODE_WRITE, done && !busy && !screen_changed && ghost_level == '0 && !frame_bit, "bad write result")

    // a pixel read holds busy one cycle, then answers with a level in range
    `ASSERT_NEXT(a_read_timing, start && !busy && mode == MODE_READ, busy && !done ##1 done && !busy && ghost_level <= GHOST_MAX, "bad read timing")

    // a refresh keeps the block busy without an early result
    `ASSERT_NEXT(a_refresh_busy, start && !busy && mode == MODE_REFRESH, busy && !done, "refresh not busy")

endmodule

bind lcd_frame_scan_with_ghosting lfs_checker u_lfs_checker (.*);

// ===== sim/tb_lcd_frame_scan_with_ghosting.sv =====
// testbench for the lcd frame scan block: byte writes, full refreshes and pixel reads
// with random idling, checked against an in-bench model of frame memory and levels
// depends on lfs_pkg and lcd_frame_scan_with_ghosting
module tb_lcd_frame_scan_with_ghosting;
    timeunit 1ns;
    timeprecision 1ps;

    import lfs_pkg::*;

    // codes with no name in the package
    localparam logic [1:0] MODE_IDLE = 2'd3;
    localparam logic [1:0] BANK_NONE = 2'd3;

    localparam int SCAN_BYTES     = DISPLAY_HEIGHT * ROW_BYTES;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int TOTAL_ITEMS    = 390;
    localparam int PHASES         = 7;
    localparam int FIXED_PHASES   = 4;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [1:0] mode;
        logic [1:0] bank_sel;
        logic [6:0] byte_addr;
        logic [7:0] byte_data;
        logic [5:0] pixel_x;
        logic [4:0] pixel_y;
    } lcd_cmd_t;

    typedef struct packed {
        logic             changed;
        logic [LVL_W-1:0] level;
        logic             fbit;
    } lcd_result_t;

    typedef int unsigned scan_list_t [SCAN_BYTES];

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic [1:0]       mode;
    logic [1:0]       bank_sel;
    logic [6:0]       byte_addr;
    logic [7:0]       byte_data;
    logic [5:0]       pixel_x;
    logic [4:0]       pixel_y;
    logic             done;
    logic             screen_changed;
    logic [LVL_W-1:0] ghost_level;
    logic             frame_bit;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [7:0]       cfg_data;

    // model of the display state
    logic [7:0]       frame_copy [FRAME_DEPTH];
    logic [LVL_W-1:0] level_copy [PIXEL_COUNT];
    bit               drawn_copy [PIXEL_COUNT];
    bit               ghost_copy;
    logic [7:0]       start_copy;

    // stimulus planning state
    bit          byte_loaded [FRAME_DEPTH];
    logic [7:0]  plan_start;
    lcd_cmd_t    cmd_backlog [$];
    lcd_cmd_t    head_cmd;
    int unsigned cmds_issued;
    bit          steady_drive;
    int unsigned gap_left;

    // checking state
    lcd_result_t owed_results [$];
    lcd_cmd_t    seen_cmd;
    lcd_result_t want;
    lcd_result_t got;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned quiet_cycles;
    logic        cmd_taken;
    logic        cfg_taken;

    lcd_frame_scan_with_ghosting i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .bank_sel       (bank_sel),
        .byte_addr      (byte_addr),
        .byte_data      (byte_data),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .done           (done),
        .screen_changed (screen_changed),
        .ghost_level    (ghost_level),
        .frame_bit      (frame_bit),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // flat frame memory index of every byte the scan fetches, in scan order
    function automatic scan_list_t scan_byte_order(input logic [7:0] start_reg);
        scan_list_t  order;
        int unsigned p;
        int unsigned b;
        p = start_reg;
        if (p >= START_OFFSET)
            p -= START_OFFSET;
        b = p >> 6;
        p = (p & 'h3f) * 2;
        for (int n = 0; n < SCAN_BYTES; n++)
        begin
            order[n] = b * BANK_BYTES + p;
            p++;
            // two rows share 16 bytes, the last 4 are skipped
            if ((p & 'hf) >= 12)
                p += 4;
            if (p >= BANK_BYTES)
            begin
                b++;
                p -= BANK_BYTES;
            end
            // the last bank holds only one row before wrapping
            if (b == BANK_COUNT - 1 && p >= ROW_BYTES)
            begin
                b = 0;
                p -= ROW_BYTES;
            end
        end
        return order;
    endfunction

    // flat frame memory index of the byte holding a pixel, via the row layout
    function automatic int unsigned pixel_byte_index(input logic [5:0] px, input logic [4:0] py);
        int unsigned r;
        r = py[3:0];
        return py[4] * BANK_BYTES + (r >> 1) * 16 + (r & 1) * ROW_BYTES + (px >> 3);
    endfunction

    // move every level one step toward its frame bit, report any change
    function automatic logic refresh_levels();
        scan_list_t  order;
        int unsigned step;
        int unsigned k;
        int unsigned prev;
        int unsigned nxt;
        logic [7:0]  pix;
        logic        changed;
        order = scan_byte_order(start_copy);
        step = ghost_copy ? 1 : GHOST_FRAMES;
        changed = 1'b0;
        for (int n = 0; n < SCAN_BYTES; n++)
        begin
            pix = frame_copy[order[n]];
            for (int i = 0; i < 8; i++)
            begin
                k = n * 8 + i;
                // first draw of a pixel always counts as a change
                if (!drawn_copy[k])
                begin
                    drawn_copy[k] = 1'b1;
                    level_copy[k] = '0;
                    changed = 1'b1;
                end
                prev = level_copy[k];
                if (pix[7 - i])
                    nxt = (prev + step > GHOST_FRAMES) ? GHOST_FRAMES : prev + step;
                else
                    nxt = (prev < step) ? 0 : prev - step;
                if (nxt != prev)
                    changed = 1'b1;
                level_copy[k] = LVL_W'(nxt);
            end
        end
        return changed;
    endfunction

    // apply one command to the model and return what the block should report
    function automatic lcd_result_t lcd_command_result(input lcd_cmd_t c);
        lcd_result_t res;
        int unsigned k;
        res = '0;
        case (c.mode)
            MODE_WRITE:
                if (c.bank_sel < BANK_COUNT)
                    frame_copy[c.bank_sel * BANK_BYTES + c.byte_addr] = c.byte_data;
            MODE_REFRESH:
                res.changed = refresh_levels();
            MODE_READ:
                if (c.pixel_x < DISPLAY_WIDTH)
                begin
                    k = c.pixel_y * DISPLAY_WIDTH + c.pixel_x;
                    if (drawn_copy[k])
                        res.level = level_copy[k];
                    res.fbit = frame_copy[pixel_byte_index(c.pixel_x, c.pixel_y)]
                                         [7 - c.pixel_x[2:0]];
                end
            default:
                ;
        endcase
        return res;
    endfunction

    task automatic flag_error(input string what);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s", $realtime, what);
    endtask

    // ---------------------------------------------------------------- planning

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    // command with every field random, callers override what matters
    function automatic lcd_cmd_t noise_cmd();
        lcd_cmd_t c;
        c.mode      = 2'($urandom_range(0, 3));
        c.bank_sel  = 2'($urandom_range(0, 3));
        c.byte_addr = 7'($urandom_range(0, 127));
        c.byte_data = 8'($urandom_range(0, 255));
        c.pixel_x   = 6'($urandom_range(0, 63));
        c.pixel_y   = 5'($urandom_range(0, 31));
        return c;
    endfunction

    task automatic push_cmd(input lcd_cmd_t c);
        if (c.mode == MODE_WRITE && c.bank_sel < BANK_COUNT)
            byte_loaded[c.bank_sel * BANK_BYTES + c.byte_addr] = 1'b1;
        cmd_backlog.push_back(c);
        cmds_issued++;
    endtask

    task automatic add_write(input logic [1:0] bank, input logic [6:0] addr,
                             input logic [7:0] data);
        lcd_cmd_t c;
        c = noise_cmd();
        c.mode = MODE_WRITE;
        c.bank_sel = bank;
        c.byte_addr = addr;
        c.byte_data = data;
        push_cmd(c);
    endtask

    // a byte must hold data before anything fetches it
    task automatic load_byte(input int unsigned idx);
        if (!byte_loaded[idx])
            add_write(2'(idx / BANK_BYTES), 7'(idx % BANK_BYTES), random_byte());
    endtask

    task automatic add_refresh();
        scan_list_t order;
        lcd_cmd_t   c;
        order = scan_byte_order(plan_start);
        foreach (order[n])
            load_byte(order[n]);
        c = noise_cmd();
        c.mode = MODE_REFRESH;
        push_cmd(c);
    endtask

    task automatic add_read(input logic [5:0] px, input logic [4:0] py);
        lcd_cmd_t c;
        if (px < DISPLAY_WIDTH)
            load_byte(pixel_byte_index(px, py));
        c = noise_cmd();
        c.mode = MODE_READ;
        c.pixel_x = px;
        c.pixel_y = py;
        push_cmd(c);
    endtask

    task automatic add_random_cmd();
        lcd_cmd_t c;
        int unsigned pick;
        logic [5:0] px;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            add_write(2'($urandom_range(0, 2)), 7'($urandom_range(0, 127)), random_byte());
        else if (pick < 56)
            add_refresh();
        else if (pick < 58)
        begin
            // a run of refreshes lets levels settle at both ends
            repeat (GHOST_FRAMES + 1)
                add_refresh();
        end
        else if (pick < 92)
        begin
            px = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(DISPLAY_WIDTH, 63))
                                             : 6'($urandom_range(0, DISPLAY_WIDTH - 1));
            add_read(px, 5'($urandom_range(0, 31)));
        end
        else
        begin
            c = noise_cmd();
            if (pick < 96)
                c.mode = MODE_IDLE;
            else
            begin
                c.mode = MODE_WRITE;
                c.bank_sel = BANK_NONE;
            end
            push_cmd(c);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_phase(input bit ghost, input logic [7:0] scan);
        write_reg(CFG_GHOST, {7'b0, ghost});
        write_reg(CFG_START, scan);
        plan_start = scan;
    endtask

    // hold off until every result owed so far has come back
    task automatic drain();
        while (results_seen != cmds_issued)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge clk)
    begin
        if (rst_n && (!start || cmd_taken))
        begin
            if (gap_left != 0)
            begin
                start <= 1'b0;
                gap_left--;
            end
            else if (cmd_backlog.size() != 0)
            begin
                head_cmd = cmd_backlog.pop_front();
                mode      <= head_cmd.mode;
                bank_sel  <= head_cmd.bank_sel;
                byte_addr <= head_cmd.byte_addr;
                byte_data <= head_cmd.byte_data;
                pixel_x   <= head_cmd.pixel_x;
                pixel_y   <= head_cmd.pixel_y;
                start     <= 1'b1;
                if (!steady_drive && $urandom_range(0, 9) == 0)
                    gap_left = $urandom_range(1, 16);
            end
            else
                start <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_taken <= 1'b0;
            cfg_taken <= 1'b0;
            quiet_cycles = 0;
        end
        else
        begin
            cmd_taken <= start && !busy;
            cfg_taken <= cfg_valid && cfg_ready;

            // compare each result with the oldest one owed
            if (done)
            begin
                got = {screen_changed, ghost_level, frame_bit};
                if (owed_results.size() == 0)
                    flag_error($sformatf("result with nothing owed: changed %0b level %0d bit %0b",
                                         got.changed, got.level, got.fbit));
                else
                begin
                    want = owed_results.pop_front();
                    if (got.changed !== want.changed || got.level !== want.level ||
                        got.fbit !== want.fbit)
                        flag_error($sformatf(
                            "mismatch: changed %0b/%0b level %0d/%0d bit %0b/%0b (exp/act)",
                            want.changed, got.changed, want.level, got.level,
                            want.fbit, got.fbit));
                end
                results_seen++;
            end

            // accepted item
            if (start && !busy)
            begin
                seen_cmd = '{mode, bank_sel, byte_addr, byte_data, pixel_x, pixel_y};
                owed_results.push_back(lcd_command_result(seen_cmd));
            end

            // register write
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_GHOST)
                    ghost_copy = cfg_data[0];
                else if (cfg_index == CFG_START)
                    start_copy = cfg_data;
            end

            // watchdog on cycles with no handshake at all
            if ((start && !busy) || done || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("Testbench completed WITH ERRORS");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------- sequence

    initial
    begin
        bit          fixed_ghost [FIXED_PHASES];
        logic [7:0]  fixed_scan  [FIXED_PHASES];
        bit          g;
        logic [7:0]  s;
        int unsigned base_items;
        int unsigned phase_goal;

        fixed_ghost = '{1'b1, 1'b1, 1'b0, 1'b1};
        fixed_scan  = '{8'h00, START_OFFSET, 8'hff, 8'h82};

        rst_n = 1'b0;
        start = 1'b0;
        mode = MODE_WRITE;
        bank_sel = '0;
        byte_addr = '0;
        byte_data = '0;
        pixel_x = '0;
        pixel_y = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GHOST;
        cfg_data = '0;
        ghost_copy = 1'b0;
        start_copy = '0;
        plan_start = '0;
        cmds_issued = 0;
        results_seen = 0;
        mismatches = 0;
        gap_left = 0;
        steady_drive = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part: full step, scan from the first byte
        set_phase(1'b0, 8'h00);
        add_write(2'd0, 7'd0, 8'ha5);
        add_read(6'd0, 5'd0);                 // byte written, pixel never drawn
        add_read(6'd63, 5'd31);               // column past the display edge
        add_write(BANK_NONE, 7'd127, 8'hff);  // bank that does not exist
        begin
            lcd_cmd_t c;
            c = '{MODE_IDLE, BANK_NONE, 7'h7f, 8'hff, 6'h3f, 5'h1f};
            push_cmd(c);
        end
        add_refresh();                        // first draw of every pixel
        add_refresh();                        // nothing moves
        add_read(6'd47, 5'd31);
        add_read(6'd0, 5'd0);
        add_read(6'd7, 5'd16);
        add_read(6'd8, 5'd1);
        add_write(2'd1, 7'd127, 8'h00);
        add_write(2'd0, 7'd0, 8'h00);
        add_refresh();
        add_read(6'd0, 5'd0);
        add_write(2'd0, 7'd0, 8'hff);
        add_refresh();
        add_read(6'd0, 5'd0);
        add_read(6'd1, 5'd0);
        drain();

        // random phases under several register settings
        base_items = cmds_issued;
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < FIXED_PHASES)
            begin
                g = fixed_ghost[p];
                s = fixed_scan[p];
            end
            else
            begin
                g = 1'($urandom_range(0, 1));
                s = 8'($urandom_range(0, 255));
            end
            set_phase(g, s);
            if (p == PHASES - 1)
                steady_drive = 1'b1;
            // spread the remaining items evenly over the phases
            phase_goal = base_items;
            if (TOTAL_ITEMS > base_items)
                phase_goal = base_items + (TOTAL_ITEMS - base_items) * (p + 1) / PHASES;
            while (cmds_issued < phase_goal)
                add_random_cmd();
            drain();
        end

        repeat (20) @(posedge clk);
        if (owed_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", owed_results.size()));

        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lfs_pkg.sv
hw/rtl/lfs_ram.sv
hw/rtl/lfs_scan_addr.sv
hw/rtl/lfs_level_alu.sv
hw/rtl/lcd_frame_scan_with_ghosting.sv
hw/rtl/lfs_checker.sv
sim/tb_lcd_frame_scan_with_ghosting.sv
